// ----- design/crm_pkg.sv -----
package crm_pkg;

  // Fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int TAPC_W     = 13;
  localparam int IDX_W      = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Q2.30 sum times Q0.16 gain lands in Q1.15 after this shift
  localparam int PROD_SHIFT = 31;

  localparam int SAT_HI = 32767;
  localparam int SAT_LO = -32768;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd10158;
  localparam logic [TAPC_W-1:0] TAPC_RESET = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIX_GAIN  = 1'b0,
    REG_TAP_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

endpackage

// ----- design/crm_in_if.sv -----
interface crm_in_if;
  import crm_pkg::*;

  logic                       valid;
  logic                       ready;
  op_t                        op;
  logic [IDX_W-1:0]           coef_index;
  logic signed [SAMPLE_W-1:0] value;

  modport source (output valid, output op, output coef_index, output value, input ready);
  modport sink   (input valid, input op, input coef_index, input value, output ready);
endinterface

// ----- design/crm_out_if.sv -----
interface crm_out_if;
  import crm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       saturated;

  modport source (output valid, output out_sample, output saturated, input ready);
  modport sink   (input valid, input out_sample, input saturated, output ready);
endinterface

// ----- design/crm_ram.sv -----
module crm_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/convolution_reverb_mix.sv -----
// Convolution reverb with dry/wet mix. A transaction with op = OP_LOAD writes one Q1.15
// impulse-response coefficient at coef_index (indexes at or above MAX_TAPS are dropped) and
// yields no result. A transaction with op = OP_SAMPLE pushes one Q1.15 sample into the delay
// line and yields one result: sample + gain * sum(coef[k] * sample[n-k]) over
// min(tap_count, MAX_TAPS) taps, rounded half up into Q1.15 and saturated to 16 bits with a
// flag. Coefficients must be loaded for every tap in use before samples are sent. After a
// sample is accepted, the single multiply-accumulate walks one tap per cycle through the
// delay-line and coefficient memories over min(tap_count, MAX_TAPS, samples taken since
// reset) taps, the read and product pipe drains, and the gain and mix steps (ST_GLO,
// ST_GHI, ST_SUM, ST_OUT) form the result. The next transaction is taken in the cycle
// after the result is loaded, so a new sample waits until the previous result is loaded,
// which the output can stall. A load leaves the input ready. The input is taken only between
// samples; a finished result sits in the output register while the next transaction is
// accepted. Register writes on cfg_we take effect at once and are to be made while no
// sample is in flight. The delay line reads as zero after reset without a clearing pass:
// a fill count masks taps older than the first sample.
module convolution_reverb_mix #(
  parameter int MAX_TAPS = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  crm_pkg::cfg_reg_t                 cfg_index,
  input  logic [crm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  crm_in_if.sink                            in_ch,
  crm_out_if.source                         out_ch
);
  import crm_pkg::*;

  localparam int AW     = $clog2(MAX_TAPS);
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int PROD_W = 2 * SAMPLE_W;
  localparam int ACC_W  = 2 * SAMPLE_W + $clog2(MAX_TAPS);
  localparam int LO_W   = ACC_W / 2;
  localparam int HI_W   = ACC_W - LO_W;
  localparam int PLO_W  = LO_W + GAIN_W;
  localparam int PHI_W  = HI_W + GAIN_W + 1;
  localparam int SUM_W  = ACC_W + GAIN_W + 1;
  localparam int WET_W  = SUM_W - PROD_SHIFT;
  localparam int MIX_W  = WET_W + 1;

  localparam logic signed [MIX_W-1:0] MIX_HI = MIX_W'(SAT_HI);
  localparam logic signed [MIX_W-1:0] MIX_LO = MIX_W'(SAT_LO);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_GLO,
    ST_GHI,
    ST_SUM,
    ST_OUT
  } state_t;

  // config registers
  logic [GAIN_W-1:0] gain_r;
  logic [TAPC_W-1:0] tapc_r;

  // control
  state_t            state_r;
  logic [AW-1:0]     wp_r;
  logic [AW-1:0]     rd_r;
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  k_r;
  logic [CNT_W-1:0]  n_r;
  logic              rv_r;
  logic              pv_r;
  logic              out_valid_r;

  // datapath
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic [PLO_W-1:0]           plo_r;
  logic signed [PHI_W-1:0]    phi_r;
  logic signed [WET_W-1:0]    wet_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_sat_r;

  logic                       in_acc;
  logic                       idx_ok;
  logic                       issue;
  logic                       out_load;
  logic [AW-1:0]              wp_inc;
  logic [AW-1:0]              rd_dec;
  logic [CNT_W-1:0]           fill_inc;
  logic [31:0]                taps32;
  logic [CNT_W-1:0]           n_start;
  logic signed [SAMPLE_W-1:0] dly_q;
  logic signed [SAMPLE_W-1:0] coef_q;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic [PLO_W-1:0]           plo_nxt;
  logic signed [PHI_W-1:0]    phi_nxt;
  logic [SUM_W-1:0]           sum_nxt;
  logic signed [MIX_W-1:0]    mix;
  logic signed [SAMPLE_W-1:0] mix_sat;
  logic                       mix_clip;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign in_acc            = in_ch.valid && in_ch.ready;
  assign idx_ok            = (32'(in_ch.coef_index) < 32'(MAX_TAPS));
  assign issue             = (state_r == ST_MAC) && (k_r < n_r);
  assign out_load          = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_sample = out_sample_r;
  assign out_ch.saturated  = out_sat_r;

  // delay line: sample written on accept, taps read newest to oldest
  crm_ram #(.DEPTH(MAX_TAPS), .WIDTH(SAMPLE_W)) u_dly_ram (
    .clk   (clk),
    .we    (in_acc && (in_ch.op == OP_SAMPLE)),
    .waddr (wp_r),
    .wdata (in_ch.value),
    .re    (issue),
    .raddr (rd_r),
    .rdata (dly_q)
  );

  // impulse response, indexed by tap number
  crm_ram #(.DEPTH(MAX_TAPS), .WIDTH(SAMPLE_W)) u_coef_ram (
    .clk   (clk),
    .we    (in_acc && (in_ch.op == OP_LOAD) && idx_ok),
    .waddr (AW'(in_ch.coef_index)),
    .wdata (in_ch.value),
    .re    (issue),
    .raddr (k_r[AW-1:0]),
    .rdata (coef_q)
  );

  always_comb begin
    wp_inc   = (wp_r == AW'(MAX_TAPS - 1)) ? '0 : wp_r + 1'b1;
    rd_dec   = (rd_r == '0) ? AW'(MAX_TAPS - 1) : rd_r - 1'b1;
    fill_inc = (fill_r == CNT_W'(MAX_TAPS)) ? fill_r : fill_r + 1'b1;
    // taps in use: tap_count capped at MAX_TAPS, and no tap older than the first sample
    taps32   = (32'(tapc_r) > 32'(MAX_TAPS)) ? 32'(MAX_TAPS) : 32'(tapc_r);
    n_start  = (32'(fill_inc) < taps32) ? fill_inc : CNT_W'(taps32);

    prod_nxt = dly_q * coef_q;

    // acc * gain split in two narrow products: acc = hi * 2^LO_W + lo
    plo_nxt  = acc_r[LO_W-1:0] * gain_r;
    phi_nxt  = $signed(acc_r[ACC_W-1:LO_W]) * $signed({1'b0, gain_r});
    sum_nxt  = {phi_r, {LO_W{1'b0}}} + SUM_W'(plo_r) + (SUM_W'(1) << (PROD_SHIFT - 1));

    mix      = MIX_W'(sample_r) + MIX_W'(wet_r);
    mix_clip = (mix > MIX_HI) || (mix < MIX_LO);
    if (mix > MIX_HI) begin
      mix_sat = SAMPLE_W'(SAT_HI);
    end else if (mix < MIX_LO) begin
      mix_sat = SAMPLE_W'(SAT_LO);
    end else begin
      mix_sat = mix[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
      tapc_r <= TAPC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIX_GAIN:  gain_r <= cfg_wdata[GAIN_W-1:0];
        REG_TAP_COUNT: tapc_r <= cfg_wdata[TAPC_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      k_r         <= '0;
      n_r         <= '0;
      rv_r        <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // MAC pipe: read issued -> data back -> product registered
      rv_r <= issue;
      pv_r <= rv_r;
      if (rv_r) begin
        prod_r <= prod_nxt;
      end

      // a new result replaces one taken in the same cycle
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_ch.op == OP_SAMPLE)) begin
            wp_r     <= wp_inc;
            fill_r   <= fill_inc;
            rd_r     <= wp_r;
            k_r      <= '0;
            n_r      <= n_start;
            acc_r    <= '0;
            sample_r <= in_ch.value;
            state_r  <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (issue) begin
            k_r  <= k_r + 1'b1;
            rd_r <= rd_dec;
          end
          if (pv_r) begin
            acc_r <= acc_r + ACC_W'(prod_r);
          end
          if (!issue && !rv_r && !pv_r) begin
            state_r <= ST_GLO;
          end
        end
        ST_GLO: begin
          plo_r   <= plo_nxt;
          state_r <= ST_GHI;
        end
        ST_GHI: begin
          phi_r   <= phi_nxt;
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          wet_r   <= sum_nxt[SUM_W-1:PROD_SHIFT];
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_sample_r <= mix_sat;
            out_sat_r    <= mix_clip;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // a result appears only out of the final mix step
  a_out_from_mix: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside mix step");

  // the MAC pipe has drained when the gain step starts
  a_mac_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GLO) |-> (!rv_r && !pv_r))
    else $error("MAC pipe busy at gain step");

  // tap counter never runs past the taps in use
  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> (k_r <= n_r))
    else $error("tap counter overran");

  // every accepted sample moves the write position
  a_wp_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.op == OP_SAMPLE)) |=> (wp_r != $past(wp_r)))
    else $error("write position did not advance");

endmodule
